@@ sv/itfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_pkg
// Shared types and constants of the idle-timeout frame receiver.
// ----------------------------------------------------------------------------
package itfr_pkg;

   // default depth of the receive ring
   localparam int RxDepthDefault = 64;

   // fixed field widths
   localparam int ByteW = 8;
   localparam int PosW  = 6;
   localparam int OpW   = 2;
   localparam int StW   = 2;

   // gap timeout after reset
   localparam logic [ByteW-1:0] GapTimeoutReset = 8'd10;

   // request operations
   typedef enum logic [OpW-1:0] {
      OP_RECEIVE = 2'd0,
      OP_TICK    = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [StW-1:0] {
      ST_DATA  = 2'd0,
      ST_BUSY  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_LOAD,
      BK_SEND
   } back_state_type;

   // work command from the front end to the back end
   typedef struct packed {
      status_type        status;
      logic [PosW-1:0]   start;
      logic [PosW-1:0]   length;
   } cmd_type;

endpackage

@@ sv/idle_timeout_frame_receiver.sv @@
`timescale 1ns / 1ps
// A busy or empty result is offered once its read command has passed the
// queue; each drained byte goes through FETCH, LOAD and SEND, one at a time.
// Throughput: one request beat per cycle while the command queue has room;
// receive beats also wait while any read command is queued or being answered.
// Reset: synchronous, active high; clears pointers, gap timer, queue and back
// end, sets gap_timeout to 10. Ring contents are not cleared.
// ----------------------------------------------------------------------------
// idle_timeout_frame_receiver
// Serial receive framer: ring buffer with an idle-gap timer gating reads.
// ----------------------------------------------------------------------------
module idle_timeout_frame_receiver
   import itfr_pkg::*;
#(
   parameter int RX_DEPTH = RxDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   // request stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] rx_byte
   input  logic [OpW-1:0]   req_tuser,   // [1:0] operation
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] data_byte, [13:8] frame_length
   output logic [StW-1:0]   rsp_tuser,   // [1:0] status
   output logic             rsp_tlast,
   // gap timeout register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [ByteW-1:0] csr_data
);

   localparam int PtrW = $clog2(RX_DEPTH);

   logic             wr_en;
   logic [PtrW-1:0]  wr_addr;
   logic [ByteW-1:0] wr_data;
   logic [PtrW-1:0]  rd_addr;
   logic [ByteW-1:0] rd_data;
   logic             cmd_push;
   logic             cmd_pop;
   logic             cmd_full;
   logic             cmd_not_empty;
   logic             back_busy;
   logic             rx_hold;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   // hold receives until every pending read command, drain or not, is answered
   assign rx_hold = cmd_not_empty || back_busy;

   itfr_front #(
      .RX_DEPTH (RX_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd),
      .cmd_full   (cmd_full),
      .rx_hold    (rx_hold)
   );

   itfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_not_empty),
      .head      (head_cmd)
   );

   itfr_ram #(
      .WIDTH (ByteW),
      .DEPTH (RX_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   itfr_back #(
      .RX_DEPTH (RX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (cmd_pop),
      .busy       (back_busy),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ sv/itfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/itfr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_front
// Accepts request beats, keeps ring pointers and the gap timer, and queues
// busy, empty and drain commands for the back end.
// ----------------------------------------------------------------------------
module itfr_front
   import itfr_pkg::*;
#(
   parameter int RX_DEPTH = RxDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [OpW-1:0]              req_tuser,
   input  logic [ByteW-1:0]            req_tdata,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ByteW-1:0]            csr_data,
   // ring write port
   output logic                        wr_en,
   output logic [$clog2(RX_DEPTH)-1:0] wr_addr,
   output logic [ByteW-1:0]            wr_data,
   // command queue
   output logic                        cmd_push,
   output cmd_type                     cmd,
   input  logic                        cmd_full,
   input  logic                        rx_hold
);

   localparam int PtrW = $clog2(RX_DEPTH);

   logic [ByteW-1:0] timeout_ff, timeout_in;
   logic [ByteW-1:0] timer_ff, timer_in;
   logic [PtrW-1:0]  wpos_ff, wpos_in;
   logic [PtrW-1:0]  rpos_ff, rpos_in;
   logic [PtrW:0]    diff;
   logic             accept;
   op_type           op;

   assign op        = op_type'(req_tuser);
   assign csr_ready = 1'b1;

   // receives wait while any read command is still queued or being answered
   assign req_tready = !cmd_full && !(rx_hold && op == OP_RECEIVE);
   assign accept     = req_tvalid && req_tready;

   // stored byte count, modulo the ring depth
   always_comb begin
      diff = (PtrW+1)'(wpos_ff) - (PtrW+1)'(rpos_ff);
      if (wpos_ff < rpos_ff) begin
         diff = diff + (PtrW+1)'(RX_DEPTH);
      end
   end

   assign wr_addr = wpos_ff;
   assign wr_data = req_tdata;

   // request decode
   always_comb begin
      timeout_in = timeout_ff;
      timer_in   = timer_ff;
      wpos_in    = wpos_ff;
      rpos_in    = rpos_ff;
      wr_en      = 1'b0;
      cmd_push   = 1'b0;
      cmd.status = ST_DATA;
      cmd.start  = PosW'(rpos_ff);
      cmd.length = PosW'(diff[PtrW-1:0]);
      if (csr_valid) begin
         timeout_in = csr_data;
      end
      if (accept) begin
         unique case (op)
            OP_RECEIVE: begin
               wr_en    = 1'b1;
               wpos_in  = (wpos_ff == PtrW'(RX_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
               timer_in = timeout_ff;
            end
            OP_TICK: begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            OP_READ: begin
               cmd_push = 1'b1;
               if (timer_ff != '0) begin
                  cmd.status = ST_BUSY;
                  cmd.length = '0;
               end else begin
                  timer_in = timeout_ff;
                  rpos_in  = wpos_ff;
                  if (diff == '0) begin
                     cmd.status = ST_EMPTY;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= GapTimeoutReset;
         timer_ff   <= '0;
         wpos_ff    <= '0;
         rpos_ff    <= '0;
      end else begin
         timeout_ff <= timeout_in;
         timer_ff   <= timer_in;
         wpos_ff    <= wpos_in;
         rpos_ff    <= rpos_in;
      end
   end

endmodule

@@ sv/itfr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module itfr_queue
   import itfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rptr_ff];

   // pointer and count update
   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

@@ sv/itfr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfr_back
// Takes queued commands and emits result beats, reading drained bytes from
// the ring one at a time into the output register.
// ----------------------------------------------------------------------------
module itfr_back
   import itfr_pkg::*;
#(
   parameter int RX_DEPTH = RxDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   // command queue
   input  logic                        cmd_valid,
   input  cmd_type                     cmd,
   output logic                        cmd_pop,
   output logic                        busy,
   // ring read port
   output logic [$clog2(RX_DEPTH)-1:0] rd_addr,
   input  logic [ByteW-1:0]            rd_data,
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,
   output logic [StW-1:0]              rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int PtrW = $clog2(RX_DEPTH);

   back_state_type   state_ff, state_in;
   logic [PtrW-1:0]  addr_ff, addr_in;
   logic [PosW-1:0]  remain_ff, remain_in;
   logic [PosW-1:0]  len_ff, len_in;
   status_type       status_ff, status_in;
   logic [ByteW-1:0] data_ff, data_in;
   logic             last_ff, last_in;

   assign rd_addr    = addr_ff;
   assign busy       = (state_ff != BK_IDLE);
   assign rsp_tvalid = (state_ff == BK_SEND);
   assign rsp_tdata  = {2'b00, len_ff, data_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   // sequencer: one result beat at a time
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      len_in    = len_ff;
      status_in = status_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      cmd_pop   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               status_in = cmd.status;
               if (cmd.status == ST_DATA) begin
                  addr_in   = cmd.start[PtrW-1:0];
                  remain_in = cmd.length;
                  len_in    = cmd.length;
                  state_in  = BK_FETCH;
               end else begin
                  len_in   = '0;
                  data_in  = '0;
                  last_in  = 1'b1;
                  state_in = BK_SEND;
               end
            end
         end
         BK_FETCH: begin
            // ring read of addr_ff lands in the next cycle
            state_in = BK_LOAD;
         end
         BK_LOAD: begin
            data_in   = rd_data;
            last_in   = (remain_ff == PosW'(1));
            remain_in = remain_ff - 1'b1;
            addr_in   = (addr_ff == PtrW'(RX_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
            state_in  = BK_SEND;
         end
         BK_SEND: begin
            if (rsp_tready) begin
               state_in = (remain_ff != '0) ? BK_FETCH : BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
   end

   // result payload and read address
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

endmodule
